### rtl/core/text_console_writer_defines.svh
// Assertion helpers shared by the console RTL.
// Both expect clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int MOVE_N = (ROWS - 1) * COLS;

  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CUR_W     = $clog2(CELLS + 1);
  localparam int COL_W     = $clog2(COLS);
  localparam int CUR_OUT_W = 11;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  // write data / address select
  localparam logic [2:0] WS_INIT  = 3'd0;
  localparam logic [2:0] WS_CLEAR = 3'd1;
  localparam logic [2:0] WS_BLANK = 3'd2;
  localparam logic [2:0] WS_MOVE  = 3'd3;
  localparam logic [2:0] WS_CHAR  = 3'd4;

  // read address select
  localparam logic RS_MOVE = 1'b0;
  localparam logic RS_CELL = 1'b1;

  // cursor update
  localparam logic [2:0] CUR_HOLD    = 3'd0;
  localparam logic [2:0] CUR_ADVANCE = 3'd1;
  localparam logic [2:0] CUR_NEWLINE = 3'd2;
  localparam logic [2:0] CUR_HOME    = 3'd3;
  localparam logic [2:0] CUR_SCROLL  = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       mem_we;
    logic [2:0] wsel;
    logic       mem_re;
    logic       rsel;
    logic [2:0] cur_cmd;
    logic       set_scrolled;
    logic       out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       at_end;
    logic       is_newline;
    logic       read_ok;
    logic       cnt_zero;
    logic       cnt_move_end;
    logic       cnt_last;
  } tcw_sts_t;

endpackage

### rtl/core/tcw_datapath.sv
`include "text_console_writer_defines.svh"

module tcw_datapath
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_cmd_t             cmd,
  output tcw_sts_t             sts,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_char_code,
  input  logic [4:0]           in_cell_row,
  input  logic [6:0]           in_cell_col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_text_attribute,
  output logic [CUR_OUT_W-1:0] out_cursor_position,
  output logic [7:0]           out_read_char,
  output logic [7:0]           out_read_attr,
  output logic                 out_scrolled
);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_r;

  logic [1:0]        op_r;
  logic [7:0]        code_r;
  logic [4:0]        cell_row_r;
  logic [6:0]        cell_col_r;

  logic [7:0]        attr_r;
  logic              scrolled_r, scrolled_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [CUR_W-1:0]  row_base_r, row_base_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;

  logic [ADDR_W-1:0] waddr, raddr, cell_addr;
  logic [15:0]       wdata;
  logic              read_ok;

  logic [CUR_OUT_W-1:0] out_cursor_r;
  logic [7:0]           out_char_r, out_attr_r;
  logic                 out_scrolled_r;

  assign cfg_ready = 1'b1;

  assign cell_addr = ADDR_W'(32'(cell_row_r) * COLS + 32'(cell_col_r));
  assign read_ok   = (32'(cell_row_r) < ROWS) && (32'(cell_col_r) < COLS);

  assign sts.op           = op_r;
  assign sts.at_end       = (cursor_r == CUR_W'(CELLS));
  assign sts.is_newline   = (code_r == NEWLINE_CODE);
  assign sts.read_ok      = read_ok;
  assign sts.cnt_zero     = (cnt_r == '0);
  assign sts.cnt_move_end = (cnt_r == ADDR_W'(MOVE_N));
  assign sts.cnt_last     = (cnt_r == ADDR_W'(CELLS - 1));

  always_comb begin
    unique case (cmd.wsel)
      WS_INIT: begin
        waddr = cnt_r;
        wdata = {ATTR_RESET, 8'h00};
      end
      WS_CLEAR: begin
        waddr = cnt_r;
        wdata = {attr_r, 8'h00};
      end
      WS_BLANK: begin
        waddr = cnt_r;
        wdata = {attr_r, SPACE_CODE};
      end
      WS_MOVE: begin
        waddr = cnt_r - ADDR_W'(1);
        wdata = rdata_r;
      end
      WS_CHAR: begin
        waddr = ADDR_W'(cursor_r);
        wdata = {attr_r, code_r};
      end
      default: begin
        waddr = cnt_r;
        wdata = {ATTR_RESET, 8'h00};
      end
    endcase
  end

  assign raddr = (cmd.rsel == RS_CELL) ? cell_addr : cnt_r + ADDR_W'(COLS);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_op;
      code_r     <= in_char_code;
      cell_row_r <= in_cell_row;
      cell_col_r <= in_cell_col;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    scrolled_nxt = scrolled_r;
    if (cmd.latch) begin
      scrolled_nxt = 1'b0;
    end else if (cmd.set_scrolled) begin
      scrolled_nxt = 1'b1;
    end
  end

  always_comb begin
    cursor_nxt   = cursor_r;
    row_base_nxt = row_base_r;
    cur_col_nxt  = cur_col_r;
    unique case (cmd.cur_cmd)
      CUR_ADVANCE: begin
        cursor_nxt = cursor_r + CUR_W'(1);
        if (cur_col_r == COL_W'(COLS - 1)) begin
          cur_col_nxt  = '0;
          row_base_nxt = row_base_r + CUR_W'(COLS);
        end else begin
          cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
      CUR_NEWLINE: begin
        cursor_nxt   = row_base_r + CUR_W'(COLS);
        row_base_nxt = row_base_r + CUR_W'(COLS);
        cur_col_nxt  = '0;
      end
      CUR_HOME: begin
        cursor_nxt   = '0;
        row_base_nxt = '0;
        cur_col_nxt  = '0;
      end
      CUR_SCROLL: begin
        cursor_nxt   = CUR_W'(MOVE_N);
        row_base_nxt = CUR_W'(MOVE_N);
        cur_col_nxt  = '0;
      end
      default: begin
        cursor_nxt = cursor_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= ATTR_RESET;
      scrolled_r <= 1'b0;
      cnt_r      <= '0;
      cursor_r   <= '0;
      row_base_r <= '0;
      cur_col_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
      scrolled_r <= scrolled_nxt;
      cnt_r      <= cnt_nxt;
      cursor_r   <= cursor_nxt;
      row_base_r <= row_base_nxt;
      cur_col_r  <= cur_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cursor_r   <= CUR_OUT_W'(cursor_r);
      out_scrolled_r <= scrolled_r;
      if (op_r == OP_READ && read_ok) begin
        out_char_r <= rdata_r[7:0];
        out_attr_r <= rdata_r[15:8];
      end else begin
        out_char_r <= 8'h00;
        out_attr_r <= 8'h00;
      end
    end
  end

  assign out_cursor_position = out_cursor_r;
  assign out_read_char       = out_char_r;
  assign out_read_attr       = out_attr_r;
  assign out_scrolled        = out_scrolled_r;

  `TCW_ASSERT_IMPL(a_cursor_range, 1'b1, cursor_r <= CUR_W'(CELLS), "cursor past end")
  `TCW_ASSERT_IMPL(a_cursor_split, 1'b1, cursor_r == row_base_r + CUR_W'(cur_col_r), "cursor split mismatch")
  `TCW_ASSERT_IMPL(a_char_in_screen, cmd.mem_we && cmd.wsel == WS_CHAR, !sts.at_end, "char write at end")

endmodule

### rtl/core/tcw_ctrl.sv
`include "text_console_writer_defines.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MOVE  = 4'd3;
  localparam logic [3:0] S_FILL  = 4'd4;
  localparam logic [3:0] S_CHAR  = 4'd5;
  localparam logic [3:0] S_CLEAR = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wsel    = WS_INIT;
    cmd.rsel    = RS_MOVE;
    cmd.cur_cmd = CUR_HOLD;
    unique case (state_r)
      S_INIT: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_INIT;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_PUT: begin
            if (sts.at_end) begin
              cmd.set_scrolled = 1'b1;
              cmd.cnt_clr      = 1'b1;
              state_nxt        = S_MOVE;
            end else begin
              state_nxt = S_CHAR;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_CLEAR;
          end
          OP_READ: begin
            cmd.mem_re = sts.read_ok;
            cmd.rsel   = RS_CELL;
            state_nxt  = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MOVE: begin
        cmd.mem_re = !sts.cnt_move_end;
        cmd.rsel   = RS_MOVE;
        cmd.mem_we = !sts.cnt_zero;
        cmd.wsel   = WS_MOVE;
        if (sts.cnt_move_end) begin
          state_nxt = S_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_BLANK;
        if (sts.cnt_last) begin
          cmd.cur_cmd = CUR_SCROLL;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_CHAR;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_CHAR: begin
        if (sts.is_newline) begin
          cmd.cur_cmd = CUR_NEWLINE;
        end else begin
          cmd.mem_we  = 1'b1;
          cmd.wsel    = WS_CHAR;
          cmd.cur_cmd = CUR_ADVANCE;
        end
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WS_CLEAR;
        if (sts.cnt_last) begin
          cmd.cur_cmd = CUR_HOME;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TCW_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == S_EXEC, "accept did not start item")
  `TCW_ASSERT_IMPL(a_scroll_at_end, state_r == S_MOVE && sts.cnt_zero, sts.at_end, "scroll without cursor at end")
  `TCW_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r, "result load lost")

endmodule

### rtl/core/text_console_writer.sv
// Put character, newline or not: the item passes the EXEC, CHAR and DONE states before the result transfer.
// Put that scrolls: passes EXEC, MOVE, FILL, CHAR and DONE, one cell moved or blanked per cycle.
// Clear: passes EXEC, CLEAR and DONE; read and unused op: EXEC and DONE.
// One item at a time; the next transfer in can share the edge of the result transfer.
// After reset a clearing pass over all ROWS*COLS cells runs before the first item is taken;
// the attribute register resets to 7 and accepts writes throughout.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_char_code,
  input  logic [4:0]           in_cell_row,
  input  logic [6:0]           in_cell_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CUR_OUT_W-1:0] out_cursor_position,
  output logic [7:0]           out_read_char,
  output logic [7:0]           out_read_attr,
  output logic                 out_scrolled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_text_attribute
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_char_code        (in_char_code),
    .in_cell_row         (in_cell_row),
    .in_cell_col         (in_cell_col),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute),
    .out_cursor_position (out_cursor_position),
    .out_read_char       (out_read_char),
    .out_read_attr       (out_read_attr),
    .out_scrolled        (out_scrolled)
  );

endmodule
